>>> rtl/core/bpc_pkg.sv
package bpc_pkg;

  localparam int TICK_W   = 8;
  localparam int CFG_T_W  = 12;
  localparam int BRIGHT_W = 7;
  localparam int ACT_W    = 2;
  localparam int IN_W     = 8;
  localparam int OUT_W    = 24;
  localparam int RES_W    = ACT_W + 1 + BRIGHT_W + BRIGHT_W + 1;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  typedef logic [ACT_W-1:0] act_t;

  localparam act_t ACT_NONE    = 2'd0;
  localparam act_t ACT_TOGGLE  = 2'd1;
  localparam act_t ACT_RESTART = 2'd2;
  localparam act_t ACT_SLEEP   = 2'd3;

  localparam logic [1:0] REG_TICK      = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE  = 2'd1;
  localparam logic [1:0] REG_LONG      = 2'd2;
  localparam logic [1:0] REG_VERY_LONG = 2'd3;

  localparam logic [TICK_W-1:0]  TICK_RST      = 8'd20;
  localparam logic [CFG_T_W-1:0] DEBOUNCE_RST  = 12'd30;
  localparam logic [CFG_T_W-1:0] LONG_RST      = 12'd800;
  localparam logic [CFG_T_W-1:0] VERY_LONG_RST = 12'd3000;

  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX  = 7'd100;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MIN  = 7'd10;
  localparam logic [BRIGHT_W-1:0] BRIGHT_STEP = 7'd10;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RST  = 7'd50;

  // per-tick status handed from the button trackers to the result logic
  typedef struct packed {
    logic up_fire;
    logic dn_fire;
  } btn_fire_t;

endpackage

>>> rtl/core/bpc_track.sv
module bpc_track import bpc_pkg::*; #(
  parameter int TIME_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               pressed,
  input  logic [TICK_W-1:0]  tick_ms,
  input  logic [CFG_T_W-1:0] deb_limit,
  output logic               fire
);

  localparam int CW = (TIME_BITS > CFG_T_W) ? TIME_BITS : CFG_T_W;

  logic                 flag_r, flag_nxt;
  logic                 fired_r, fired_nxt;
  logic [TIME_BITS-1:0] hold_r, hold_nxt;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] hold_sat;

  assign sum      = {1'b0, hold_r} + (TIME_BITS+1)'(tick_ms);
  assign hold_sat = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

  always_comb begin
    flag_nxt  = flag_r;
    fired_nxt = fired_r;
    hold_nxt  = hold_r;
    fire      = 1'b0;
    if (!pressed) begin
      flag_nxt = 1'b0;
    end else if (!flag_r) begin
      // first pressed tick: restart the hold count
      flag_nxt  = 1'b1;
      hold_nxt  = '0;
      fired_nxt = 1'b0;
    end else begin
      hold_nxt = hold_sat;
      if (!fired_r && (CW'(hold_sat) > CW'(deb_limit))) begin
        fired_nxt = 1'b1;
        fire      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r  <= 1'b0;
      fired_r <= 1'b0;
      hold_r  <= '0;
    end else if (step) begin
      flag_r  <= flag_nxt;
      fired_r <= fired_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule

>>> rtl/core/bpc_power.sv
module bpc_power import bpc_pkg::*; #(
  parameter int TIME_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               pressed,
  input  logic [TICK_W-1:0]  tick_ms,
  input  logic [CFG_T_W-1:0] deb_limit,
  input  logic [CFG_T_W-1:0] long_ms,
  input  logic [CFG_T_W-1:0] very_long_ms,
  output act_t               action
);

  localparam int CW = (TIME_BITS > CFG_T_W) ? TIME_BITS : CFG_T_W;

  logic                 flag_r, flag_nxt;
  logic [TIME_BITS-1:0] hold_r, hold_nxt;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] hold_sat;
  logic [CW-1:0]        h, deb, lng, vlng;

  assign sum      = {1'b0, hold_r} + (TIME_BITS+1)'(tick_ms);
  assign hold_sat = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  assign h        = CW'(hold_sat);
  assign deb      = CW'(deb_limit);
  assign lng      = CW'(long_ms);
  assign vlng     = CW'(very_long_ms);

  always_comb begin
    flag_nxt = flag_r;
    hold_nxt = hold_r;
    action   = ACT_NONE;
    if (pressed) begin
      flag_nxt = 1'b1;
      hold_nxt = flag_r ? hold_sat : '0;
    end else if (flag_r) begin
      // classify on the first released tick
      flag_nxt = 1'b0;
      hold_nxt = hold_sat;
      if (h > deb && h < vlng && h >= lng) begin
        action = ACT_RESTART;
      end else if (h >= vlng) begin
        action = ACT_SLEEP;
      end else if (h > deb) begin
        action = ACT_TOGGLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
      hold_r <= '0;
    end else if (step) begin
      flag_r <= flag_nxt;
      hold_r <= hold_nxt;
    end
  end

endmodule

>>> rtl/core/button_press_classifier.sv
// Button press classifier.
// Input stream: one word per poll tick, in_tdata holds the three active-low
// button pins (power, up, down). Result stream: exactly one word per input
// word, carrying the power action, display flag, brightness and the
// backlight value and write strobe for that tick.
// An accepted word enters the input register, and its result is loaded into
// the output register, which drives out_tvalid, once that register is free.
// Throughput: one word per cycle while the output is not stalled. Each tick
// updates the hold counters, display flag and brightness, and the next tick
// needs that state, so that update loop sets the rate.
// When out_tready is low the result register holds its word; the input
// register still takes one more word if it is empty, then in_tready drops
// until the result is taken.
// Reset (synchronous, active low) empties both registers, clears all
// button tracking, turns the display on, sets brightness to 50 and loads
// the default timing registers. The user must write the APB registers only
// while the stream is idle; the block itself does not enforce this.
module button_press_classifier import bpc_pkg::*; #(
  parameter int TIME_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,     // [0] power_level, [1] up_level, [2] down_level
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,    // [1:0] power_action, [2] display_enabled,
                                          // [9:3] brightness_level, [16:10] backlight_value,
                                          // [17] backlight_write
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [TICK_W-1:0]  tick_r;
  logic [CFG_T_W-1:0] deb_r, long_r, vlong_r;
  logic               cfg_wr;

  logic               in_valid_r;
  logic [2:0]         lvl_r;
  logic               out_valid_r;
  logic [RES_W-1:0]   out_data_r;
  logic               adv, step, proc;

  act_t               act;
  btn_fire_t          fires;
  logic               disp_r, disp_nxt;
  logic [BRIGHT_W-1:0] bright_r, bright_nxt;
  logic [BRIGHT_W-1:0] bl_val;
  logic               bl_wr;
  logic [BRIGHT_W:0]  up_sum;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= TICK_RST;
      deb_r   <= DEBOUNCE_RST;
      long_r  <= LONG_RST;
      vlong_r <= VERY_LONG_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_TICK:      tick_r  <= cfg_pwdata[TICK_W-1:0];
        REG_DEBOUNCE:  deb_r   <= cfg_pwdata[CFG_T_W-1:0];
        REG_LONG:      long_r  <= cfg_pwdata[CFG_T_W-1:0];
        REG_VERY_LONG: vlong_r <= cfg_pwdata[CFG_T_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_TICK:      cfg_prdata = DATA_W'(tick_r);
      REG_DEBOUNCE:  cfg_prdata = DATA_W'(deb_r);
      REG_LONG:      cfg_prdata = DATA_W'(long_r);
      REG_VERY_LONG: cfg_prdata = DATA_W'(vlong_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // stream control
  assign adv       = !out_valid_r || out_tready;
  assign step      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (adv) out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) lvl_r <= in_tdata[2:0];
  end

  bpc_power #(.TIME_BITS(TIME_BITS)) u_power (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .pressed      (!lvl_r[0]),
    .tick_ms      (tick_r),
    .deb_limit    (deb_r),
    .long_ms      (long_r),
    .very_long_ms (vlong_r),
    .action       (act)
  );

  // restart and sleep stop the tick before up and down are looked at
  assign proc = (act != ACT_RESTART) && (act != ACT_SLEEP);

  bpc_track #(.TIME_BITS(TIME_BITS)) u_up (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step && proc),
    .pressed     (!lvl_r[1]),
    .tick_ms     (tick_r),
    .deb_limit   (deb_r),
    .fire        (fires.up_fire)
  );

  bpc_track #(.TIME_BITS(TIME_BITS)) u_dn (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step && proc),
    .pressed     (!lvl_r[2]),
    .tick_ms     (tick_r),
    .deb_limit   (deb_r),
    .fire        (fires.dn_fire)
  );

  assign up_sum = {1'b0, bright_r} + {1'b0, BRIGHT_STEP};

  always_comb begin
    disp_nxt   = disp_r;
    bright_nxt = bright_r;
    bl_val     = '0;
    bl_wr      = 1'b0;
    if (act == ACT_SLEEP) begin
      bl_wr = 1'b1;
    end else if (act == ACT_TOGGLE) begin
      disp_nxt = !disp_r;
      bl_wr    = 1'b1;
      bl_val   = disp_nxt ? bright_r : '0;
    end
    if (proc && fires.up_fire) begin
      if (bright_r < BRIGHT_MAX) begin
        bright_nxt = (up_sum > {1'b0, BRIGHT_MAX}) ? BRIGHT_MAX : up_sum[BRIGHT_W-1:0];
      end
      if (disp_nxt) begin
        bl_wr  = 1'b1;
        bl_val = bright_nxt;
      end
    end
    if (proc && fires.dn_fire) begin
      if (bright_nxt > BRIGHT_MIN) bright_nxt = bright_nxt - BRIGHT_STEP;
      if (disp_nxt) begin
        bl_wr  = 1'b1;
        bl_val = bright_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_r   <= 1'b1;
      bright_r <= BRIGHT_RST;
    end else if (step) begin
      disp_r   <= disp_nxt;
      bright_r <= bright_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_data_r <= {bl_wr, bl_val, bright_nxt, disp_nxt, act};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-RES_W){1'b0}}, out_data_r};

`ifndef SYNTHESIS
  a_word_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> in_valid_r)
    else $error("pending input word dropped while output stalled");

  a_disp_toggle_only: assert property (@(posedge clk) disable iff (!rst_n)
    (step && act != ACT_TOGGLE) |=> (disp_r == $past(disp_r)))
    else $error("display flag changed without a toggle");

  a_restart_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[ACT_W-1:0] == ACT_RESTART) |-> !out_data_r[RES_W-1])
    else $error("backlight written on restart");

  a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (bright_r >= BRIGHT_MIN && bright_r <= BRIGHT_MAX))
    else $error("brightness left its range");
`endif

endmodule
